>>> design/bxr_pkg.sv
// shared constants and types for the bounded xorshift64* random unit
// no dependencies
package bxr_pkg;

  localparam int unsigned GEN_W   = 64;
  localparam int unsigned BOUND_W = 32;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned MUL_STEPS = GEN_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int unsigned DIV_CNT_W = $clog2(GEN_W);

  localparam logic [GEN_W-1:0] GOLDEN_SEED = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [GEN_W-1:0] STAR_MULT   = 64'd2685821657736338717;

  localparam int unsigned SHIFT_A = 12;
  localparam int unsigned SHIFT_B = 25;
  localparam int unsigned SHIFT_C = 27;

  typedef logic [GEN_W-1:0]   gen_word_t;
  typedef logic [BOUND_W-1:0] bound_t;

endpackage

>>> design/bxr_gen.sv
// xorshift64 state register with a digit-serial multiply by the star constant
// depends on bxr_pkg
module bxr_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              seed_wr,
  input  bxr_pkg::gen_word_t seed,
  input  logic              step,
  output bxr_pkg::gen_word_t value,
  output logic              done
);

  bxr_pkg::gen_word_t state_r, state_nxt;
  bxr_pkg::gen_word_t mcand_r, mcand_nxt;
  bxr_pkg::gen_word_t acc_r, acc_nxt;
  logic [bxr_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  bxr_pkg::gen_word_t xs;
  logic [bxr_pkg::DIGIT_W-1:0] digit;
  logic [bxr_pkg::GEN_W+bxr_pkg::DIGIT_W-1:0] partial;

  always_comb begin
    xs = state_r ^ (state_r >> bxr_pkg::SHIFT_A);
    xs = xs ^ (xs << bxr_pkg::SHIFT_B);
    xs = xs ^ (xs >> bxr_pkg::SHIFT_C);
  end

  // one constant digit per cycle while busy and no seed is written, low digit first
  assign digit   = bxr_pkg::STAR_MULT[cnt_r*bxr_pkg::DIGIT_W +: bxr_pkg::DIGIT_W];
  assign partial = mcand_r * digit;

  always_comb begin
    state_nxt = state_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (seed_wr) begin
      state_nxt = (seed == '0) ? bxr_pkg::GOLDEN_SEED : seed;
    end else if (step) begin
      state_nxt = xs;
      mcand_nxt = xs;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      acc_nxt   = acc_r + partial[bxr_pkg::GEN_W-1:0];
      mcand_nxt = mcand_r << bxr_pkg::DIGIT_W;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == bxr_pkg::MUL_CNT_W'(bxr_pkg::MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bxr_pkg::GOLDEN_SEED;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
  end

  assign value = acc_r;
  assign done  = done_r;

endmodule

>>> design/bxr_div.sv
// radix-2 restoring remainder unit: 64-bit dividend mod 32-bit divisor
// depends on bxr_pkg
module bxr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bxr_pkg::gen_word_t dividend,
  input  bxr_pkg::bound_t    divisor,
  output bxr_pkg::bound_t    remainder,
  output logic               done
);

  bxr_pkg::gen_word_t dvd_r, dvd_nxt;
  bxr_pkg::bound_t    dsr_r, dsr_nxt;
  bxr_pkg::bound_t    rem_r, rem_nxt;
  logic [bxr_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [bxr_pkg::BOUND_W:0] shifted;
  logic [bxr_pkg::BOUND_W:0] diff;

  assign shifted = {rem_r, dvd_r[bxr_pkg::GEN_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so one compare and subtract per bit
      rem_nxt = diff[bxr_pkg::BOUND_W] ? shifted[bxr_pkg::BOUND_W-1:0]
                                       : diff[bxr_pkg::BOUND_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder = rem_r;
  assign done      = done_r;

endmodule

>>> design/bounded_xorshift64star_random_unit.sv
// an empty range or a span of one needs no generator output: the result goes from the check
// state to the done state; otherwise two 64-bit remainder passes of one bit per cycle run,
// plus a 4-bit digit-serial multiply for each rejected generator output.
// one transaction at a time: the next input can be taken in the same cycle that the result
// is in the output register.
// synchronous active-low reset clears control, output valid and restores the golden seed state.
module bounded_xorshift64star_random_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_lower_bound,
  input  logic signed [31:0]   in_upper_bound,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_drawn_value,
  output logic                 out_range_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [63:0]          cfg_seed_value
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_THR, S_CMP, S_MOD, S_DONE
  } st_t;

  st_t state_r, state_nxt;
  bxr_pkg::bound_t lo_r, lo_nxt;
  bxr_pkg::bound_t hi_r, hi_nxt;
  bxr_pkg::bound_t thr_r, thr_nxt;
  bxr_pkg::bound_t res_val_r, res_val_nxt;
  logic res_err_r, res_err_nxt;
  logic v_ready_r, v_ready_nxt;
  logic out_valid_r, out_valid_nxt;
  bxr_pkg::bound_t out_val_r, out_val_nxt;
  logic out_err_r, out_err_nxt;

  logic [bxr_pkg::BOUND_W:0] diff;
  bxr_pkg::bound_t span;
  logic range_bad;
  bxr_pkg::gen_word_t thr_dividend;
  bxr_pkg::gen_word_t div_dividend;
  bxr_pkg::gen_word_t gen_v;
  bxr_pkg::bound_t div_rem;
  logic gen_done, div_done;
  logic gen_step, div_start;
  logic in_fire;

  assign in_fire   = in_valid && !in_stall;
  assign diff      = {hi_r[bxr_pkg::BOUND_W-1], hi_r} - {lo_r[bxr_pkg::BOUND_W-1], lo_r};
  assign span      = diff[bxr_pkg::BOUND_W-1:0];
  assign range_bad = ($signed(hi_r) <= $signed(lo_r));
  // (2^64 - span) mod span
  assign thr_dividend = '0 - {{(bxr_pkg::GEN_W-bxr_pkg::BOUND_W){1'b0}}, span};
  assign div_dividend = (state_r == S_CHK) ? thr_dividend : gen_v;

  bxr_gen u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed_wr (cfg_valid && cfg_ready),
    .seed    (cfg_seed_value),
    .step    (gen_step),
    .value   (gen_v),
    .done    (gen_done)
  );

  bxr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (span),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    thr_nxt       = thr_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    v_ready_nxt   = v_ready_r || gen_done;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    gen_step      = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          lo_nxt    = in_lower_bound;
          hi_nxt    = in_upper_bound;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (range_bad) begin
          res_val_nxt = '0;
          res_err_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (span == bxr_pkg::BOUND_W'(1)) begin
          res_val_nxt = lo_r;
          res_err_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          // threshold division and first generator step run side by side
          div_start   = 1'b1;
          gen_step    = 1'b1;
          v_ready_nxt = 1'b0;
          state_nxt   = S_THR;
        end
      end
      S_THR: begin
        if (div_done) begin
          thr_nxt   = div_rem;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (v_ready_r) begin
          if (gen_v >= {{(bxr_pkg::GEN_W-bxr_pkg::BOUND_W){1'b0}}, thr_r}) begin
            div_start = 1'b1;
            state_nxt = S_MOD;
          end else begin
            gen_step    = 1'b1;
            v_ready_nxt = 1'b0;
          end
        end
      end
      S_MOD: begin
        if (div_done) begin
          res_val_nxt = lo_r + div_rem;
          res_err_nxt = 1'b0;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v_ready_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v_ready_r   <= v_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    thr_r     <= thr_nxt;
    res_val_r <= res_val_nxt;
    res_err_r <= res_err_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_val_r;
  assign out_range_error = out_err_r;

endmodule

>>> design/bxr_checker.sv
// port-level checks for the bounded xorshift64* random unit, bound to the top level
// depends on bounded_xorshift64star_random_unit
module bxr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_drawn_value,
  input logic               out_range_error,
  input logic               cfg_ready
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drawn_value)
                               && $stable(out_range_error))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_drawn_value == 32'sd0)
    else $error("range error with nonzero value");

  // one transaction in flight: input and seed port close right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("input taken while busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear control");

endmodule

bind bounded_xorshift64star_random_unit bxr_checker u_bxr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_drawn_value (out_drawn_value),
  .out_range_error (out_range_error),
  .cfg_ready       (cfg_ready)
);
